### sv/sync_header_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef SYNC_HEADER_FRAME_RECEIVER_MACROS_SVH
`define SYNC_HEADER_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SHFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/shfr_pkg.sv
// Types and constants of the sync header frame receiver.
`timescale 1ns / 1ps
package shfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_FIRST_SYNC  = 3'd0;
  localparam cfg_idx_t REG_SECOND_SYNC = 3'd1;
  localparam cfg_idx_t REG_VERSION     = 3'd2;
  localparam cfg_idx_t REG_MAX_LEN     = 3'd3;

  // Register reset values
  localparam byte_t FIRST_SYNC_RST  = 8'd170;
  localparam byte_t SECOND_SYNC_RST = 8'd85;
  localparam byte_t VERSION_RST     = 8'd2;
  localparam byte_t MAX_LEN_RST     = 8'd128;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_VERSION = 3'd2,
    PH_CMD     = 3'd3,
    PH_SEQ     = 3'd4,
    PH_LEN     = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef struct packed {
    byte_t first_sync;
    byte_t second_sync;
    byte_t version;
    byte_t max_len;
  } cfg_t;

  typedef struct packed {
    byte_t command;
    byte_t sequence_res;
    byte_t payload_length;
    logic  has_payload;
    byte_t payload_byte;
    byte_t byte_index;
    logic  last;
  } result_t;

  // Result handed from the parser to the output buffer
  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

endpackage

### sv/shfr_ifs.sv
// Channel interfaces: received bytes in, frame results out.
`timescale 1ns / 1ps
interface shfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shfr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] sequence_res;
  logic [7:0] payload_length;
  logic       has_payload;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       last;

  modport source (
    output valid, output command, output sequence_res, output payload_length,
    output has_payload, output payload_byte, output byte_index, output last,
    input ready
  );
  modport sink (
    input valid, input command, input sequence_res, input payload_length,
    input has_payload, input payload_byte, input byte_index, input last,
    output ready
  );
endinterface

### sv/shfr_parser.sv
// Frame parser: sync hunt, header capture and payload tagging, one byte a cycle while accept is high.
`timescale 1ns / 1ps
module shfr_parser (
  input  logic            clk,
  input  logic            rst,
  input  shfr_pkg::cfg_t  cfg,
  input  logic            accept,
  input  shfr_pkg::byte_t rx_byte,
  output shfr_pkg::push_t push
);
  import shfr_pkg::*;

  phase_t phase, phase_next;
  byte_t  held_command, held_command_next;
  byte_t  held_sequence, held_sequence_next;
  byte_t  held_length, held_length_next;
  byte_t  bytes_received, bytes_received_next;
  logic   fin;

  // Final payload byte of the frame
  assign fin = ({1'b0, bytes_received} + 9'd1) >= {1'b0, held_length};

  // Next state
  always_comb begin
    phase_next          = phase;
    held_command_next   = held_command;
    held_sequence_next  = held_sequence;
    held_length_next    = held_length;
    bytes_received_next = bytes_received;
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == cfg.second_sync) phase_next = PH_VERSION;
        else if (rx_byte == cfg.first_sync) phase_next = PH_SYNC2;
        else phase_next = PH_SYNC1;
      end
      PH_VERSION: begin
        if (rx_byte == cfg.version) phase_next = PH_CMD;
        else phase_next = PH_SYNC1;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        phase_next        = PH_SEQ;
      end
      PH_SEQ: begin
        held_sequence_next = rx_byte;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        held_length_next    = rx_byte;
        bytes_received_next = '0;
        if (rx_byte > cfg.max_len || rx_byte == '0) phase_next = PH_SYNC1;
        else phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bytes_received_next = bytes_received + 8'd1;
        if (fin) phase_next = PH_SYNC1;
      end
      default: begin
        phase_next = (rx_byte == cfg.first_sync) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  // Result for the byte in this cycle
  always_comb begin
    push.valid               = 1'b0;
    push.data.command        = held_command;
    push.data.sequence_res   = held_sequence;
    push.data.payload_length = held_length;
    push.data.has_payload    = 1'b1;
    push.data.payload_byte   = rx_byte;
    push.data.byte_index     = bytes_received;
    push.data.last           = fin;
    case (phase)
      PH_LEN: begin
        push.valid               = accept && rx_byte == '0;
        push.data.payload_length = '0;
        push.data.has_payload    = 1'b0;
        push.data.payload_byte   = '0;
        push.data.byte_index     = '0;
        push.data.last           = 1'b1;
      end
      PH_PAYLOAD: push.valid = accept;
      default: push.valid = 1'b0;
    endcase
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Held header fields and payload count
  always_ff @(posedge clk) begin
    if (accept) begin
      held_command   <= held_command_next;
      held_sequence  <= held_sequence_next;
      held_length    <= held_length_next;
      bytes_received <= bytes_received_next;
    end
  end

endmodule

### sv/shfr_out_buf.sv
// Output register with a skid stage, so input keeps flowing while a result waits.
`timescale 1ns / 1ps
module shfr_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  shfr_pkg::push_t  push,
  output logic             space,
  output logic             out_valid,
  output shfr_pkg::result_t out_data,
  input  logic             out_ready
);
  import shfr_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;

  // Room while the skid stage is empty
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      main_valid <= skid_valid || push.valid;
      skid_valid <= 1'b0;
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Data registers
  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push.data;
    end else if (push.valid) begin
      skid_data <= push.data;
    end
  end

endmodule

### sv/sync_header_frame_receiver.sv
// Top level: configuration registers, frame parser and output buffer.
// A result for a byte transfer is registered in the output register, or in the skid stage while that register is held.
// Throughput: one byte per cycle; rx_ch.ready drops only while both the output
// register and the skid stage hold results.
// Reset: synchronous rst returns the parser to the sync hunt, empties the buffer
// and restores the register defaults (170, 85, 2, 128).
`timescale 1ns / 1ps
`include "sync_header_frame_receiver_macros.svh"
module sync_header_frame_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  shfr_pkg::cfg_idx_t  cfg_index,
  input  shfr_pkg::byte_t     cfg_data,
  shfr_byte_if.sink           rx_ch,
  shfr_frame_if.source        res_ch
);
  import shfr_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    space;
  push_t   push;
  result_t out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_sync  <= FIRST_SYNC_RST;
      cfg.second_sync <= SECOND_SYNC_RST;
      cfg.version     <= VERSION_RST;
      cfg.max_len     <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SYNC:  cfg.first_sync  <= cfg_data;
        REG_SECOND_SYNC: cfg.second_sync <= cfg_data;
        REG_VERSION:     cfg.version     <= cfg_data;
        REG_MAX_LEN:     cfg.max_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx_ch.ready = space;
  assign accept      = rx_ch.valid && space;

  shfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_ch.rx_byte),
    .push    (push)
  );

  shfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (res_ch.valid),
    .out_data  (out_data),
    .out_ready (res_ch.ready)
  );

  assign res_ch.command        = out_data.command;
  assign res_ch.sequence_res   = out_data.sequence_res;
  assign res_ch.payload_length = out_data.payload_length;
  assign res_ch.has_payload    = out_data.has_payload;
  assign res_ch.payload_byte   = out_data.payload_byte;
  assign res_ch.byte_index     = out_data.byte_index;
  assign res_ch.last           = out_data.last;

  // Empty-frame notice carries zeroed payload fields and closes the frame
  `SHFR_ASSERT_IMP(a_empty_notice, res_ch.valid && !res_ch.has_payload, res_ch.last && res_ch.byte_index == 8'd0 && res_ch.payload_byte == 8'd0 && res_ch.payload_length == 8'd0, "empty-frame notice malformed")
  // Payload index stays inside the declared length
  `SHFR_ASSERT_IMP(a_index_range, res_ch.valid && res_ch.has_payload, res_ch.byte_index < res_ch.payload_length, "payload index beyond frame length")
  // A full skid stage implies the output register is occupied
  `SHFR_ASSERT_IMP(a_skid_order, !rx_ch.ready, res_ch.valid, "skid full with empty output register")
  // A held skid entry keeps a result presented on the next cycle
  `SHFR_ASSERT_NEXT(a_skid_drain, !rx_ch.ready, res_ch.valid, "skid entry lost")

endmodule
